// ===== sv/modbus_servo_command_framer_core_assert.svh =====
// ----------------------------------------------------------------------------
// modbus servo command framer assertion macros
// concurrent checks on clk with asynchronous reset arst_n, removed under SYNTH
// ----------------------------------------------------------------------------
`ifndef MODBUS_SERVO_COMMAND_FRAMER_CORE_ASSERT_SVH
`define MODBUS_SERVO_COMMAND_FRAMER_CORE_ASSERT_SVH

`ifndef SYNTH

// property holds in the same cycle
`define MSCF_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("mscf assertion failed");

// antecedent in one cycle implies consequent in the next
`define MSCF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mscf assertion failed");

`else

`define MSCF_ASSERT(lbl, prop)
`define MSCF_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== sv/mscf_pkg.sv =====
// ----------------------------------------------------------------------------
// mscf_pkg
// shared types, codes and the crc byte update for the servo command framer
// ----------------------------------------------------------------------------
package mscf_pkg;

	// operation codes
	localparam logic [2:0] OP_ON    = 3'd0;
	localparam logic [2:0] OP_OFF   = 3'd1;
	localparam logic [2:0] OP_SPEED = 3'd2;
	localparam logic [2:0] OP_CCW   = 3'd3;
	localparam logic [2:0] OP_CW    = 3'd4;
	localparam logic [2:0] OP_STOP  = 3'd5;

	// configuration register indexes
	localparam logic [1:0] CFG_SLAVE_ADDRESS = 2'd0;
	localparam logic [1:0] CFG_SPEED_MIN     = 2'd1;
	localparam logic [1:0] CFG_SPEED_MAX     = 2'd2;

	localparam logic [7:0]  SLAVE_ADDRESS_RST = 8'h7F;
	localparam logic [15:0] SPEED_MIN_RST     = 16'd100;
	localparam logic [15:0] SPEED_MAX_RST     = 16'd800;

	// frame layout
	localparam int unsigned FRAME_LEN = 13;
	localparam int unsigned CRC_SPAN  = 11;
	localparam int unsigned CNT_W     = $clog2(FRAME_LEN);

	localparam logic [CNT_W-1:0] IDX_ADDR    = CNT_W'(0);
	localparam logic [CNT_W-1:0] IDX_FUNC    = CNT_W'(1);
	localparam logic [CNT_W-1:0] IDX_REG_HI  = CNT_W'(2);
	localparam logic [CNT_W-1:0] IDX_REG_LO  = CNT_W'(3);
	localparam logic [CNT_W-1:0] IDX_QTY_HI  = CNT_W'(4);
	localparam logic [CNT_W-1:0] IDX_QTY_LO  = CNT_W'(5);
	localparam logic [CNT_W-1:0] IDX_BCOUNT  = CNT_W'(6);
	localparam logic [CNT_W-1:0] IDX_D0      = CNT_W'(7);
	localparam logic [CNT_W-1:0] IDX_D1      = CNT_W'(8);
	localparam logic [CNT_W-1:0] IDX_D2      = CNT_W'(9);
	localparam logic [CNT_W-1:0] IDX_D3      = CNT_W'(10);
	localparam logic [CNT_W-1:0] IDX_CRC_LO  = CNT_W'(CRC_SPAN);
	localparam logic [CNT_W-1:0] IDX_CRC_HI  = CNT_W'(FRAME_LEN - 1);

	localparam logic [7:0] FUNC_WRITE_MULTI = 8'h10;
	localparam logic [7:0] QTY_HI           = 8'h00;
	localparam logic [7:0] QTY_LO           = 8'h02;
	localparam logic [7:0] BYTE_COUNT       = 8'h04;
	localparam logic [7:0] POWER_REG_HI     = 8'h02;
	localparam logic [7:0] POWER_REG_LO     = 8'h3C;
	localparam logic [7:0] JOG_REG_HI       = 8'h04;
	localparam logic [7:0] JOG_REG_LO       = 8'h0A;
	localparam logic [7:0] JOG_DIR_HI       = 8'h13;
	localparam logic [7:0] JOG_CCW_LO       = 8'h86;
	localparam logic [7:0] JOG_CW_LO        = 8'h87;
	localparam logic [7:0] POWER_ON_LO      = 8'h01;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// per-frame content that varies between commands
	typedef struct packed {
		logic [7:0] addr;
		logic       jog_reg;  // 1: jog register, 0: power register
		logic [7:0] d0;
		logic [7:0] d1;
	} frame_t;

	// crc-16/modbus, one byte, lsb first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== sv/modbus_servo_command_framer_core.sv =====
// ----------------------------------------------------------------------------
// modbus_servo_command_framer_core
// servo command to modbus rtu write-multiple-registers frame
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall) takes one command: operation and speed.
//   output channel (out_valid / out_stall) gives the 13 frame bytes in send
//   order, one per beat, last_byte set on the crc high byte.
//   a command is held in an input register, then loaded into the byte
//   serializer, whose output register then presents its first byte.
//   throughput: one output byte per cycle while out_stall is low, set by the
//   byte serializer; the next command is taken while the current frame streams
//   and is loaded on the beat of the crc high byte, so frames go back to back.
//   commands that give no frame (set speed outside speed_min..speed_max, codes
//   6 and 7) are dropped on input.
//   out_stall holds the output byte and pauses the frame; in_stall rises once
//   the input register holds a command the serializer cannot yet take.
//   reset clears all beats in flight and sets slave_address to 127,
//   speed_min to 100 and speed_max to 800.
//   cfg writes land on the edge where cfg_we is high; index 3 is ignored.
// ----------------------------------------------------------------------------
module modbus_servo_command_framer_core
	import mscf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  operation,
	input  logic signed [15:0] speed,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  frame_byte,
	output logic        last_byte
);

	logic [7:0]         slave_address_q;
	logic signed [15:0] speed_min_q;
	logic signed [15:0] speed_max_q;

	logic       valid_s1;
	logic       jog_reg_s1;
	logic [7:0] d0_s1;
	logic [7:0] d1_s1;

	logic       keep;
	logic       jog_reg;
	logic [7:0] d0;
	logic [7:0] d1;
	logic       in_accept;
	logic       ld_ready;
	frame_t     ld_frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q <= SLAVE_ADDRESS_RST;
			speed_min_q     <= SPEED_MIN_RST;
			speed_max_q     <= SPEED_MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SLAVE_ADDRESS: slave_address_q <= cfg_data[7:0];
				CFG_SPEED_MIN:     speed_min_q     <= cfg_data;
				CFG_SPEED_MAX:     speed_max_q     <= cfg_data;
				default:           ;
			endcase
		end
	end

	// decode the command into register select and first two data bytes
	always_comb begin
		keep    = 1'b1;
		jog_reg = 1'b1;
		d0      = 8'h00;
		d1      = 8'h00;
		unique case (operation)
			OP_ON: begin
				jog_reg = 1'b0;
				d1      = POWER_ON_LO;
			end
			OP_OFF: begin
				jog_reg = 1'b0;
			end
			OP_SPEED: begin
				keep = (speed >= speed_min_q) && (speed <= speed_max_q);
				d0   = speed[15:8];
				d1   = speed[7:0];
			end
			OP_CCW: begin
				d0 = JOG_DIR_HI;
				d1 = JOG_CCW_LO;
			end
			OP_CW: begin
				d0 = JOG_DIR_HI;
				d1 = JOG_CW_LO;
			end
			OP_STOP: begin
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign in_stall  = valid_s1 && !ld_ready;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= keep;
		end else if (ld_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			jog_reg_s1 <= jog_reg;
			d0_s1      <= d0;
			d1_s1      <= d1;
		end
	end

	assign ld_frame = '{addr: slave_address_q, jog_reg: jog_reg_s1, d0: d0_s1, d1: d1_s1};

	mscf_serializer u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.ld_valid   (valid_s1),
		.ld_frame   (ld_frame),
		.ld_ready   (ld_ready),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.frame_byte (frame_byte),
		.last_byte  (last_byte)
	);

endmodule

// ===== sv/mscf_serializer.sv =====
// ----------------------------------------------------------------------------
// mscf_serializer
// streams one 13-byte frame a byte per beat, crc built as the bytes go out
// ----------------------------------------------------------------------------
module mscf_serializer
	import mscf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       ld_valid,
	input  frame_t     ld_frame,
	output logic       ld_ready,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] frame_byte,
	output logic       last_byte
);

`include "modbus_servo_command_framer_core_assert.svh"

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [15:0]      crc_q;
	frame_t           frame_q;
	logic             out_valid_q;
	logic [7:0]       frame_byte_q;
	logic             last_byte_q;

	logic       advance;
	logic       at_last;
	logic [7:0] cur_byte;

	assign advance  = !out_valid_q || !out_stall;
	assign at_last  = (cnt_q == IDX_CRC_HI);
	assign ld_ready = advance && (!busy_q || at_last);

	always_comb begin
		unique case (cnt_q)
			IDX_ADDR:   cur_byte = frame_q.addr;
			IDX_FUNC:   cur_byte = FUNC_WRITE_MULTI;
			IDX_REG_HI: cur_byte = frame_q.jog_reg ? JOG_REG_HI : POWER_REG_HI;
			IDX_REG_LO: cur_byte = frame_q.jog_reg ? JOG_REG_LO : POWER_REG_LO;
			IDX_QTY_HI: cur_byte = QTY_HI;
			IDX_QTY_LO: cur_byte = QTY_LO;
			IDX_BCOUNT: cur_byte = BYTE_COUNT;
			IDX_D0:     cur_byte = frame_q.d0;
			IDX_D1:     cur_byte = frame_q.d1;
			IDX_D2:     cur_byte = 8'h00;
			IDX_D3:     cur_byte = 8'h00;
			IDX_CRC_LO: cur_byte = crc_q[7:0];
			IDX_CRC_HI: cur_byte = crc_q[15:8];
			default:    cur_byte = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			crc_q       <= CRC_INIT;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= busy_q;
			// next frame is loaded on the beat that sends the crc high byte
			if (ld_ready) begin
				busy_q <= ld_valid;
				cnt_q  <= '0;
				crc_q  <= CRC_INIT;
			end else if (busy_q) begin
				if (cnt_q < IDX_CRC_LO) begin
					crc_q <= crc_byte(crc_q, cur_byte);
				end
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && busy_q) begin
			frame_byte_q <= cur_byte;
			last_byte_q  <= at_last;
		end
		if (ld_ready && ld_valid) begin
			frame_q <= ld_frame;
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_byte = frame_byte_q;
	assign last_byte  = last_byte_q;

	`MSCF_ASSERT(a_idle_cnt_zero, !busy_q |-> (cnt_q == '0))
	`MSCF_ASSERT(a_crc_starts_fresh, (busy_q && cnt_q == '0) |-> (crc_q == CRC_INIT))
	`MSCF_ASSERT(a_cnt_in_frame, cnt_q <= IDX_CRC_HI)
	`MSCF_ASSERT_NEXT(a_last_beat_marked, (busy_q && advance && at_last),
		(out_valid_q && last_byte_q))

endmodule

// ===== tb/sv/tb_modbus_servo_command_framer_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_modbus_servo_command_framer_core
// drives servo commands and configuration into the framer, predicts each
// 13-byte modbus rtu frame including its crc, and checks every output beat
// in order against the predicted bytes and the last-byte mark
// ----------------------------------------------------------------------------
module tb_modbus_servo_command_framer_core
	import mscf_pkg::*;
();

	localparam int unsigned CYCLE_LIMIT   = 600000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned END_CYCLES    = 40;
	localparam int unsigned PHASE_FRAMES  = 22;
	localparam int unsigned RAND_PHASES   = 6;

	// operation codes the block has no use for
	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;
	// register index with no register behind it
	localparam logic [1:0] CFG_SPARE   = 2'd3;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_beat_t;

	class servo_frame_book;
		logic [7:0]         slave_addr;
		logic signed [15:0] speed_lo;
		logic signed [15:0] speed_hi;
		frame_beat_t        pending[$];
		int unsigned        mismatches;
		int unsigned        frames;
		int unsigned        beats_seen;
		int unsigned        dropped;

		function new();
			slave_addr = SLAVE_ADDRESS_RST;
			speed_lo   = SPEED_MIN_RST;
			speed_hi   = SPEED_MAX_RST;
			mismatches = 0;
			frames     = 0;
			beats_seen = 0;
			dropped    = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] value);
			case (idx)
				CFG_SLAVE_ADDRESS: slave_addr = value[7:0];
				CFG_SPEED_MIN:     speed_lo = value;
				CFG_SPEED_MAX:     speed_hi = value;
				default: ;
			endcase
		endfunction

		// builds the expected frame for one accepted command, 1 if one is due
		function bit take_command(logic [2:0] op, logic signed [15:0] spd);
			logic [7:0]  f [FRAME_LEN];
			logic [15:0] crc;
			frame_beat_t b;
			foreach (f[i]) f[i] = 8'h00;
			f[0] = slave_addr;
			f[1] = FUNC_WRITE_MULTI;
			f[4] = QTY_HI;
			f[5] = QTY_LO;
			f[6] = BYTE_COUNT;
			case (op)
				OP_ON: begin
					f[2] = POWER_REG_HI;
					f[3] = POWER_REG_LO;
					f[8] = POWER_ON_LO;
				end
				OP_OFF: begin
					f[2] = POWER_REG_HI;
					f[3] = POWER_REG_LO;
				end
				OP_SPEED: begin
					if (spd < speed_lo || spd > speed_hi) begin
						dropped++;
						return 0;
					end
					f[2] = JOG_REG_HI;
					f[3] = JOG_REG_LO;
					f[7] = spd[15:8];
					f[8] = spd[7:0];
				end
				OP_CCW: begin
					f[2] = JOG_REG_HI;
					f[3] = JOG_REG_LO;
					f[7] = JOG_DIR_HI;
					f[8] = JOG_CCW_LO;
				end
				OP_CW: begin
					f[2] = JOG_REG_HI;
					f[3] = JOG_REG_LO;
					f[7] = JOG_DIR_HI;
					f[8] = JOG_CW_LO;
				end
				OP_STOP: begin
					f[2] = JOG_REG_HI;
					f[3] = JOG_REG_LO;
				end
				default: begin
					dropped++;
					return 0;
				end
			endcase
			// crc-16/modbus over address through last data byte, lsb first
			crc = CRC_INIT;
			for (int i = 0; i < CRC_SPAN; i++) begin
				crc = crc ^ {8'h00, f[i]};
				repeat (8) crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
			end
			f[CRC_SPAN]     = crc[7:0];
			f[CRC_SPAN + 1] = crc[15:8];
			for (int i = 0; i < FRAME_LEN; i++) begin
				b.data = f[i];
				b.last = (i == FRAME_LEN - 1);
				pending.push_back(b);
			end
			frames++;
			return 1;
		endfunction

		function void check_frame_byte(logic [7:0] fb, logic lb);
			frame_beat_t want;
			beats_seen++;
			if (pending.size() == 0) begin
				mismatches++;
				$display("%t unexpected frame beat: expected none, actual byte %h last %b",
					$time, fb, lb);
				return;
			end
			want = pending.pop_front();
			if (fb !== want.data) begin
				mismatches++;
				$display("%t frame_byte mismatch: expected %h actual %h", $time, want.data, fb);
			end
			if (lb !== want.last) begin
				mismatches++;
				$display("%t last_byte mismatch: expected %b actual %b", $time, want.last, lb);
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [15:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         operation;
	logic signed [15:0] speed;
	logic               out_valid;
	logic               out_stall;
	logic [7:0]         frame_byte;
	logic               last_byte;

	servo_frame_book book;
	bit          quiet_tail;
	int unsigned gap_pct;
	int unsigned stall_pct;
	int unsigned stall_left;
	int unsigned sent_cmds;
	int unsigned framed_cmds;
	int unsigned cfg_writes;
	int unsigned cycle_count;

	modbus_servo_command_framer_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.speed      (speed),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.frame_byte (frame_byte),
		.last_byte  (last_byte)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// receiver stall bursts
	initial begin
		out_stall  = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (quiet_tail) begin
				out_stall  = 1'b0;
				stall_left = 0;
			end else if (stall_left != 0) begin
				out_stall = 1'b1;
				stall_left--;
			end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
				out_stall  = 1'b1;
				stall_left = $urandom_range(1, 18) - 1;
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			book.check_frame_byte(frame_byte, last_byte);
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%t run stopped at cycle limit with %0d bytes outstanding",
			$time, book.pending.size());
		$display("modbus_servo_command_framer_core test failed");
		$finish;
	end

	// entered and left at a falling edge; valid stays high into the next command unless a random gap drops it
	task automatic send_command(input logic [2:0] op, input logic signed [15:0] spd);
		in_valid  = 1'b1;
		operation = op;
		speed     = spd;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		if (book.take_command(op, spd)) framed_cmds++;
		sent_cmds++;
		@(negedge clk);
		if (!quiet_tail && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
	endtask

	// hold off until every frame is out, plus room for a dropped command
	task automatic settle();
		in_valid = 1'b0;
		while (book.pending.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [15:0] value);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(negedge clk);
		cfg_we = 1'b0;
		book.write_reg(idx, value);
		cfg_writes++;
	endtask

	task automatic random_config();
		int lo;
		int hi;
		int t;
		int unsigned pick;
		cfg_write(CFG_SLAVE_ADDRESS, 16'($urandom_range(0, 65535)));
		pick = $urandom_range(0, 9);
		lo   = int'($urandom_range(0, 65535)) - 32768;
		hi   = int'($urandom_range(0, 65535)) - 32768;
		if ((pick == 1 && lo < hi) || (pick > 1 && lo > hi)) begin
			t  = lo;
			lo = hi;
			hi = t;
		end
		if (pick == 0) begin
			lo = -32768;
			hi = 32767;
		end else if (pick == 2) begin
			hi = lo;
		end
		cfg_write(CFG_SPEED_MIN, lo[15:0]);
		cfg_write(CFG_SPEED_MAX, hi[15:0]);
		if ($urandom_range(0, 3) == 0) cfg_write(CFG_SPARE, 16'($urandom_range(0, 65535)));
		case ($urandom_range(0, 2))
			0: gap_pct = 0;
			1: gap_pct = 10;
			default: gap_pct = 35;
		endcase
		case ($urandom_range(0, 2))
			0: stall_pct = 0;
			1: stall_pct = 8;
			default: stall_pct = 30;
		endcase
	endtask

	task automatic random_command();
		int unsigned pick;
		int unsigned s;
		int lo;
		int hi;
		logic [2:0] op;
		logic signed [15:0] spd;
		pick = $urandom_range(0, 99);
		spd  = 16'($urandom_range(0, 65535));
		if (pick < 5) begin
			op = (pick < 3) ? OP_SPARE_LO : OP_SPARE_HI;
		end else if (pick < 45) begin
			op = OP_SPEED;
			lo = book.speed_lo;
			hi = book.speed_hi;
			// mostly speeds inside the window so frames come out
			if (lo <= hi) begin
				s = $urandom_range(0, 9);
				if (s < 7)
					spd = 16'(lo + int'($urandom_range(0, hi - lo)));
				else if (s == 7)
					spd = lo[15:0];
				else if (s == 8)
					spd = hi[15:0];
			end
		end else begin
			op = 3'($urandom_range(OP_ON, OP_STOP));
		end
		send_command(op, spd);
	endtask

	initial begin
		int unsigned target;
		book        = new();
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = CFG_SLAVE_ADDRESS;
		cfg_data    = 16'h0000;
		in_valid    = 1'b0;
		operation   = OP_ON;
		speed       = 16'sd0;
		quiet_tail  = 1'b0;
		gap_pct     = 10;
		stall_pct   = 10;
		sent_cmds   = 0;
		framed_cmds = 0;
		cfg_writes  = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: address 7f, window 100..800
		send_command(OP_ON, 16'sd0);
		send_command(OP_OFF, 16'sd0);
		send_command(OP_SPEED, 16'sd100);
		send_command(OP_SPEED, 16'sd800);
		send_command(OP_SPEED, 16'sd99);
		send_command(OP_SPEED, 16'sd801);
		send_command(OP_CCW, 16'sd0);
		send_command(OP_CW, 16'sd0);
		send_command(OP_STOP, 16'sd0);
		send_command(OP_SPARE_LO, 16'sd300);
		send_command(OP_SPARE_HI, 16'sd300);

		// address 00 with junk in the upper half, full window
		settle();
		cfg_write(CFG_SLAVE_ADDRESS, 16'hFF00);
		cfg_write(CFG_SPEED_MIN, 16'h8000);
		cfg_write(CFG_SPEED_MAX, 16'h7FFF);
		cfg_write(CFG_SPARE, 16'h1234);
		send_command(OP_SPEED, 16'sh8000);
		send_command(OP_SPEED, 16'sh7FFF);
		send_command(OP_SPEED, 16'sd0);
		send_command(OP_SPEED, 16'sh5555);
		send_command(OP_SPEED, 16'shAAAA);

		// address ff, min 5 above max -5: no speed is taken
		settle();
		cfg_write(CFG_SLAVE_ADDRESS, 16'h00FF);
		cfg_write(CFG_SPEED_MIN, 16'h0005);
		cfg_write(CFG_SPEED_MAX, 16'hFFFB);
		send_command(OP_SPEED, 16'sd0);
		send_command(OP_SPEED, 16'sd5);
		send_command(OP_ON, 16'sd0);

		// single-point window at -7
		settle();
		cfg_write(CFG_SPEED_MIN, 16'hFFF9);
		cfg_write(CFG_SPEED_MAX, 16'hFFF9);
		send_command(OP_SPEED, 16'shFFF9);
		send_command(OP_SPEED, 16'shFFFA);

		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			settle();
			random_config();
			if (phase == RAND_PHASES - 1) quiet_tail = 1'b1;
			target = framed_cmds + PHASE_FRAMES;
			while (framed_cmds < target) random_command();
		end

		settle();
		repeat (END_CYCLES) @(negedge clk);
		if (book.pending.size() != 0) begin
			book.mismatches++;
			$display("%t missing frame bytes: expected %0d more, actual 0",
				$time, book.pending.size());
		end
		$display("sent %0d commands (%0d framed, %0d dropped) over %0d register writes",
			sent_cmds, book.frames, book.dropped, cfg_writes);
		$display("checked %0d frame bytes, %0d mismatches", book.beats_seen, book.mismatches);
		if (book.mismatches == 0) begin
			$display("modbus_servo_command_framer_core test passed");
		end else begin
			$display("modbus_servo_command_framer_core test failed");
		end
		$finish;
	end

endmodule
